FILE: design/bsem_pkg.sv
`timescale 1ns / 1ps

package bsem_pkg;

   // Field widths on the request and response channels
   localparam int OP_W        = 3;
   localparam int TASK_FIELD_W = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [OP_W-1:0] {
      OP_WAIT     = 3'd0,
      OP_TRY_WAIT = 3'd1,
      OP_POST     = 3'd2,
      OP_TRY_POST = 3'd3,
      OP_READ     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE        = 2'd0,
      ST_QUEUED      = 2'd1,
      ST_WOULD_BLOCK = 2'd2,
      ST_QUEUE_FULL  = 2'd3
   } status_type;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_COUNT     = 1'd1;

   // Queue control from the semaphore logic
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // Queue status back to the semaphore logic
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

FILE: design/bsem_fifo.sv
`timescale 1ns / 1ps

module bsem_fifo #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  bsem_pkg::fifo_ctrl_type    ctrl,
   input  logic [TASK_ID_BITS-1:0]    wr_data,
   output bsem_pkg::fifo_stat_type    stat,
   output logic [TASK_ID_BITS-1:0]    head_data
);
   import bsem_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OccW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [OccW-1:0] FullOcc = OccW'(QUEUE_DEPTH);

   logic [TASK_ID_BITS-1:0] mem [QUEUE_DEPTH];

   logic [PtrW-1:0]         head_ff, head_in;
   logic [PtrW-1:0]         tail_ff, tail_in;
   logic [OccW-1:0]         occ_ff, occ_in;
   logic [TASK_ID_BITS-1:0] rd_data_ff;
   logic                    byp_ff, byp_in;
   logic [TASK_ID_BITS-1:0] byp_data_ff;

   // Pointer and occupancy update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      if (clear) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end else begin
         if (ctrl.push) begin
            tail_in = (tail_ff == LastPtr) ? '0 : tail_ff + 1'b1;
            occ_in  = occ_ff + 1'b1;
         end
         if (ctrl.pop) begin
            head_in = (head_ff == LastPtr) ? '0 : head_ff + 1'b1;
            occ_in  = occ_ff - 1'b1;
         end
      end
   end

   // A write into the slot that becomes the head is forwarded past the read
   assign byp_in = ctrl.push && !clear && (tail_ff == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         byp_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         byp_ff  <= byp_in;
      end
   end

   // Slot memory: one write port, one registered read of the next head
   always_ff @(posedge clock) begin
      if (ctrl.push && !clear) begin
         mem[tail_ff] <= wr_data;
      end
      rd_data_ff  <= mem[head_in];
      byp_data_ff <= wr_data;
   end

   assign head_data  = byp_ff ? byp_data_ff : rd_data_ff;
   assign stat.empty = (occ_ff == '0);
   assign stat.full  = (occ_ff == FullOcc);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push && !clear |-> !stat.full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop && !clear |-> !stat.empty)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.push && !ctrl.pop && !clear |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("occupancy did not follow push");

endmodule

FILE: design/bounded_semaphore_with_wait_queues.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Contents
// req_      in   req_tvalid/req_tready  tdata: operation, task_id
// rsp_      out  rsp_tvalid/rsp_tready  tdata: status, woken_valid, woken_task, count_value
// csr_      in   csr_valid/csr_ready    csr_index, csr_data (0 initial count, 1 max count)
//
// A request passes from acceptance to response through the input register, then
// one pass of compare and queue push/pop into the response register.
// One request is accepted per cycle unless the response stalls; queue heads are prefetched.
// Reset gives count 0, max count 1 and both queues empty; no clearing pass.
// A stalled response holds the input register, and req_tready drops only then.

module bounded_semaphore_with_wait_queues #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [2:0] operation, [10:3] task_id, [15:11] zero
   input  logic [bsem_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] status, [2] woken_valid, [10:3] woken_task, [26:11] count_value,
   // [31:27] zero
   output logic [bsem_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bsem_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bsem_pkg::COUNT_W-1:0]          csr_data
);
   import bsem_pkg::*;

   // Input register
   logic                    in_valid_ff;
   logic [OP_W-1:0]         op_ff;
   logic [TASK_ID_BITS-1:0] id_ff;

   // Semaphore state
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      max_ff;

   // Response register
   logic                    out_valid_ff;
   status_type              status_ff, status_in;
   logic                    woken_valid_ff, woken_valid_in;
   logic [TASK_FIELD_W-1:0] woken_task_ff, woken_task_in;
   logic [COUNT_W-1:0]      count_out_ff;

   fifo_ctrl_type           wait_ctrl, post_ctrl;
   fifo_stat_type           wait_stat, post_stat;
   logic [TASK_ID_BITS-1:0] wait_head, post_head;

   logic advance;
   logic init_write;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign init_write = csr_valid && (csr_index == REG_INITIAL_COUNT);

   // Input register load
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         op_ff <= req_tdata[OP_W-1:0];
         id_ff <= TASK_ID_BITS'(req_tdata[OP_W +: TASK_FIELD_W]);
      end
   end

   // Request decode: count compare plus at most one queue push or pop
   always_comb begin
      count_in       = count_ff;
      status_in      = ST_DONE;
      woken_valid_in = 1'b0;
      woken_task_in  = '0;
      wait_ctrl      = '0;
      post_ctrl      = '0;
      case (op_ff)
         OP_WAIT: begin
            if (count_ff == '0) begin
               if (wait_stat.full) begin
                  status_in = ST_QUEUE_FULL;
               end else begin
                  status_in      = ST_QUEUED;
                  wait_ctrl.push = advance;
               end
            end else if (!post_stat.empty) begin
               post_ctrl.pop  = advance;
               woken_valid_in = 1'b1;
               woken_task_in  = TASK_FIELD_W'(post_head);
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_TRY_WAIT: begin
            if (count_ff == '0) begin
               status_in = ST_WOULD_BLOCK;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_POST: begin
            if (count_ff >= max_ff) begin
               if (post_stat.full) begin
                  status_in = ST_QUEUE_FULL;
               end else begin
                  status_in      = ST_QUEUED;
                  post_ctrl.push = advance;
               end
            end else if (!wait_stat.empty) begin
               wait_ctrl.pop  = advance;
               woken_valid_in = 1'b1;
               woken_task_in  = TASK_FIELD_W'(wait_head);
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_TRY_POST: begin
            if (count_ff >= max_ff) begin
               status_in = ST_WOULD_BLOCK;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            // read count and unused codes change nothing
         end
      endcase
   end

   // Count and maximum registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= COUNT_W'(1);
      end else begin
         if (init_write) begin
            count_ff <= csr_data;
         end else if (advance) begin
            count_ff <= count_in;
         end
         if (csr_valid && (csr_index == REG_MAX_COUNT)) begin
            max_ff <= csr_data;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         status_ff      <= status_in;
         woken_valid_ff <= woken_valid_in;
         woken_task_ff  <= woken_task_in;
         count_out_ff   <= count_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, count_out_ff, woken_task_ff, woken_valid_ff, status_ff};

   bsem_fifo #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_wait_q (
      .clock     (clock),
      .reset     (reset),
      .clear     (init_write),
      .ctrl      (wait_ctrl),
      .wr_data   (id_ff),
      .stat      (wait_stat),
      .head_data (wait_head)
   );

   bsem_fifo #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_post_q (
      .clock     (clock),
      .reset     (reset),
      .clear     (init_write),
      .ctrl      (post_ctrl),
      .wr_data   (id_ff),
      .stat      (post_stat),
      .head_data (post_head)
   );

   a_woken_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && woken_valid_ff |-> status_ff == ST_DONE)
      else $error("woken task reported on a request that did not complete");

   a_woken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !woken_valid_ff |-> woken_task_ff == '0)
      else $error("woken task id not zero without a release");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request side stalled without a response stall");

   a_one_queue: assert property (@(posedge clock) disable iff (reset)
      !((wait_ctrl.push || wait_ctrl.pop) && (post_ctrl.push || post_ctrl.pop)))
      else $error("both queues touched by one request");

endmodule

FILE: tb/sv/tb_bounded_semaphore_with_wait_queues.sv
`timescale 1ns / 1ps

module tb_bounded_semaphore_with_wait_queues;
   import bsem_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;

   // Spare operation codes; the block treats them as a count read
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

   typedef struct {
      status_type          status;
      logic                woken_valid;
      logic [7:0]          woken_task;
      logic [COUNT_W-1:0]  count_value;
   } sem_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [COUNT_W-1:0]     csr_data   = '0;

   // Shadow semaphore state
   logic [COUNT_W-1:0] sem_count = '0;
   logic [COUNT_W-1:0] sem_max   = 16'd1;
   logic [7:0]         waiter_ids[$];
   logic [7:0]         poster_ids[$];

   sem_result_type pending_results[$];

   int  error_count     = 0;
   int  requests_sent   = 0;
   int  responses_seen  = 0;
   int  wakeups_seen    = 0;
   int  blocked_seen    = 0;
   int  full_seen       = 0;
   int  refused_seen    = 0;
   int  cycle_count     = 0;
   bit  quiet_mode      = 1'b0;

   bounded_semaphore_with_wait_queues #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TASK_ID_BITS(8)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_mode || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Semaphore behavior for one request; updates shadow state
   function automatic sem_result_type semaphore_step(input logic [OP_W-1:0] op,
                                                     input logic [7:0] task_id);
      sem_result_type r;
      r.status      = ST_DONE;
      r.woken_valid = 1'b0;
      r.woken_task  = '0;
      case (op)
         OP_WAIT: begin
            if (sem_count == 0) begin
               if (waiter_ids.size() < QUEUE_DEPTH) begin
                  waiter_ids.push_back(task_id);
                  r.status = ST_QUEUED;
               end else begin
                  r.status = ST_QUEUE_FULL;
               end
            end else if (poster_ids.size() > 0) begin
               // poster's deferred increment cancels this decrement
               r.woken_valid = 1'b1;
               r.woken_task  = poster_ids.pop_front();
            end else begin
               sem_count = sem_count - 1'b1;
            end
         end
         OP_TRY_WAIT: begin
            if (sem_count == 0) r.status = ST_WOULD_BLOCK;
            else sem_count = sem_count - 1'b1;
         end
         OP_POST: begin
            if (sem_count >= sem_max) begin
               if (poster_ids.size() < QUEUE_DEPTH) begin
                  poster_ids.push_back(task_id);
                  r.status = ST_QUEUED;
               end else begin
                  r.status = ST_QUEUE_FULL;
               end
            end else if (waiter_ids.size() > 0) begin
               // waiter's deferred decrement cancels this increment
               r.woken_valid = 1'b1;
               r.woken_task  = waiter_ids.pop_front();
            end else begin
               sem_count = sem_count + 1'b1;
            end
         end
         OP_TRY_POST: begin
            if (sem_count >= sem_max) r.status = ST_WOULD_BLOCK;
            else sem_count = sem_count + 1'b1;
         end
         default: ;
      endcase
      r.count_value = sem_count;
      return r;
   endfunction

   // Send one request, record its expected response on acceptance
   task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] task_id);
      int             idle;
      sem_result_type r;
      idle = pick_idle();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, task_id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = semaphore_step(op, task_id);
      pending_results.push_back(r);
      requests_sent++;
      if (r.woken_valid) wakeups_seen++;
      if (r.status == ST_QUEUED) blocked_seen++;
      if (r.status == ST_QUEUE_FULL) full_seen++;
      if (r.status == ST_WOULD_BLOCK) refused_seen++;
   endtask

   // Stop sending and let every outstanding response come back
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write max count, and optionally reload the count (which also empties the queues)
   task automatic program_limits(input logic [COUNT_W-1:0] limit_value, input bit reload,
                                 input logic [COUNT_W-1:0] start_value);
      settle_idle();
      csr_valid <= 1'b1;
      csr_index <= REG_MAX_COUNT;
      csr_data  <= limit_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sem_max = limit_value;
      if (reload) begin
         csr_index <= REG_INITIAL_COUNT;
         csr_data  <= start_value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sem_count = start_value;
         waiter_ids.delete();
         poster_ids.delete();
      end
      csr_valid <= 1'b0;
   endtask

   // Response stalls
   always @(posedge clock) begin
      int stall_left;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left = pick_idle();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int expected_value,
                                       input int actual_value);
      if (expected_value != actual_value) begin
         $display("%0t: %s mismatch, expected %0d actual %0d",
                  $time, name, expected_value, actual_value);
         error_count++;
      end
   endfunction

   // Response checker
   always @(posedge clock) begin
      sem_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing expected, expected none actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_tdata[1:0]);
            check_field("woken_valid", want.woken_valid, rsp_tdata[2]);
            check_field("woken_task", want.woken_task, rsp_tdata[10:3]);
            check_field("count_value", want.count_value, rsp_tdata[26:11]);
         end
      end
   end

   // Run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d responses outstanding",
                  $time, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // Reset values, read and spare operation codes, try operations at both ends
   task automatic test_basic_ops();
      send_request(OP_READ, 8'h00);
      send_request(OP_TRY_WAIT, 8'h01);
      send_request(OP_TRY_POST, 8'h02);
      send_request(OP_TRY_POST, 8'h80);
      send_request(OP_TRY_WAIT, 8'h7F);
      send_request(OP_SPARE_A, 8'hFF);
      send_request(OP_SPARE_B, 8'h55);
      send_request(OP_SPARE_C, 8'hAA);
   endtask

   // Blocking and release of waiters and posters; try operations never release
   task automatic test_wakeups();
      send_request(OP_WAIT, 8'h10);
      send_request(OP_WAIT, 8'hEF);
      send_request(OP_POST, 8'h20);
      send_request(OP_POST, 8'h21);
      send_request(OP_POST, 8'h22);
      send_request(OP_POST, 8'h33);
      send_request(OP_TRY_WAIT, 8'h44);
      send_request(OP_TRY_POST, 8'h45);
      send_request(OP_WAIT, 8'h46);
   endtask

   // Count above max, max of zero, count at the top of its range
   task automatic test_limit_corners();
      program_limits(16'd4, 1'b1, 16'd9);
      send_request(OP_POST, 8'h01);
      send_request(OP_TRY_POST, 8'h02);
      send_request(OP_TRY_WAIT, 8'h03);
      send_request(OP_WAIT, 8'h04);
      program_limits(16'd0, 1'b0, 16'd0);
      send_request(OP_TRY_POST, 8'h05);
      send_request(OP_POST, 8'h06);
      program_limits(16'hFFFF, 1'b1, 16'hFFFF);
      send_request(OP_TRY_POST, 8'h07);
      send_request(OP_TRY_WAIT, 8'h08);
      send_request(OP_POST, 8'h09);
      send_request(OP_READ, 8'h0A);
   endtask

   // Fill both queues past their depth, then drain them
   task automatic test_queue_full();
      program_limits(16'd1, 1'b1, 16'd0);
      repeat (QUEUE_DEPTH + 2) send_request(OP_WAIT, 8'($urandom_range(0, 255)));
      repeat (QUEUE_DEPTH + 3) send_request(OP_POST, 8'($urandom_range(0, 255)));
      repeat (QUEUE_DEPTH) send_request(OP_POST, 8'($urandom_range(0, 255)));
      repeat (QUEUE_DEPTH + 3) send_request(OP_WAIT, 8'($urandom_range(0, 255)));
   endtask

   // Bursts of waits and posts that push queues toward full, mixed with noise
   task automatic run_traffic(input int item_budget);
      int sent;
      int kind;
      int burst;
      sent = 0;
      while (sent < item_budget) begin
         kind       = $urandom_range(0, 9);
         burst      = $urandom_range(1, 20);
         quiet_mode = ($urandom_range(0, 4) == 0);
         if (burst > item_budget - sent) burst = item_budget - sent;
         repeat (burst) begin
            case (kind)
               0, 1, 2: send_request(OP_WAIT, 8'($urandom_range(0, 255)));
               3, 4, 5: send_request(OP_POST, 8'($urandom_range(0, 255)));
               6, 7:    send_request(3'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
               8:       send_request($urandom_range(0, 1) ? OP_TRY_WAIT : OP_TRY_POST,
                                     8'($urandom_range(0, 255)));
               default: send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            endcase
            sent++;
         end
      end
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_traffic();
      program_limits(16'd1, 1'b1, 16'd0);
      run_traffic(60);
      program_limits(16'd8, 1'b1, 16'd5);
      run_traffic(55);
      // Max change alone keeps count and queues
      program_limits(16'd2, 1'b0, 16'd0);
      run_traffic(55);
      program_limits(16'hFFFF, 1'b1, 16'hFFFF);
      run_traffic(55);
      program_limits(16'hFFFF, 1'b1, 16'd0);
      run_traffic(60);
      program_limits(16'd3, 1'b1, 16'd12);
      run_traffic(55);
      program_limits(16'hFFFF, 1'b1, 16'hFFFE);
      run_traffic(55);
      program_limits(16'd1, 1'b1, 16'd1);
      run_traffic(55);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_wakeups();
      test_limit_corners();
      test_queue_full();
      test_random_traffic();
      settle_idle();
      $display("%0d requests, %0d responses checked: %0d wakeups, %0d blocked,",
               requests_sent, responses_seen, wakeups_seen, blocked_seen);
      $display("%0d queue full, %0d would block, %0d mismatches",
               full_seen, refused_seen, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
